/* rtl/msgtok_pkg.sv */
package msgtok_pkg;

    // width of the open-object counter, 33 to 64
    localparam int PENDING_WIDTH = 40;
    localparam int LEN_WIDTH     = 32;
    localparam int CHILD_WIDTH   = LEN_WIDTH + 1;

    typedef enum logic [3:0] {
        KIND_NIL   = 4'd0,
        KIND_BOOL  = 4'd1,
        KIND_INT   = 4'd2,
        KIND_UINT  = 4'd3,
        KIND_F32   = 4'd4,
        KIND_F64   = 4'd5,
        KIND_STR   = 4'd6,
        KIND_BIN   = 4'd7,
        KIND_EXT   = 4'd8,
        KIND_ARRAY = 4'd9,
        KIND_MAP   = 4'd10,
        KIND_BYTE  = 4'd11,
        KIND_ERROR = 4'd12
    } token_kind_t;

    localparam logic [7:0] MP_NIL      = 8'hc0;
    localparam logic [7:0] MP_INVALID  = 8'hc1;
    localparam logic [7:0] MP_FALSE    = 8'hc2;
    localparam logic [7:0] MP_TRUE     = 8'hc3;
    localparam logic [7:0] MP_BIN8     = 8'hc4;
    localparam logic [7:0] MP_BIN16    = 8'hc5;
    localparam logic [7:0] MP_BIN32    = 8'hc6;
    localparam logic [7:0] MP_EXT8     = 8'hc7;
    localparam logic [7:0] MP_EXT16    = 8'hc8;
    localparam logic [7:0] MP_EXT32    = 8'hc9;
    localparam logic [7:0] MP_FLOAT32  = 8'hca;
    localparam logic [7:0] MP_FLOAT64  = 8'hcb;
    localparam logic [7:0] MP_UINT8    = 8'hcc;
    localparam logic [7:0] MP_UINT16   = 8'hcd;
    localparam logic [7:0] MP_UINT32   = 8'hce;
    localparam logic [7:0] MP_UINT64   = 8'hcf;
    localparam logic [7:0] MP_INT8     = 8'hd0;
    localparam logic [7:0] MP_INT16    = 8'hd1;
    localparam logic [7:0] MP_INT32    = 8'hd2;
    localparam logic [7:0] MP_INT64    = 8'hd3;
    localparam logic [7:0] MP_FIXEXT1  = 8'hd4;
    localparam logic [7:0] MP_FIXEXT2  = 8'hd5;
    localparam logic [7:0] MP_FIXEXT4  = 8'hd6;
    localparam logic [7:0] MP_FIXEXT8  = 8'hd7;
    localparam logic [7:0] MP_FIXEXT16 = 8'hd8;
    localparam logic [7:0] MP_STR8     = 8'hd9;
    localparam logic [7:0] MP_STR16    = 8'hda;
    localparam logic [7:0] MP_STR32    = 8'hdb;
    localparam logic [7:0] MP_ARRAY16  = 8'hdc;
    localparam logic [7:0] MP_ARRAY32  = 8'hdd;
    localparam logic [7:0] MP_MAP16    = 8'hde;
    localparam logic [7:0] MP_MAP32    = 8'hdf;

    typedef struct packed {
        logic [7:0]               tag;
        logic [3:0]               hdr_left;
        logic [63:0]              accum;
        logic [7:0]               ext_hold;
        logic [LEN_WIDTH-1:0]     payload_left;
        logic [PENDING_WIDTH-1:0] pending;
    } parse_state_t;

    typedef struct packed {
        logic        emit;
        token_kind_t kind;
        logic [63:0] value;
        logic [7:0]  ext_type;
        logic        done;
    } token_t;

endpackage

/* rtl/msgtok_decode.sv */
module msgtok_decode (
    input  msgtok_pkg::parse_state_t cur,
    input  logic [7:0]               stream_byte,
    input  logic                     payload_pass,
    output msgtok_pkg::parse_state_t nxt,
    output msgtok_pkg::token_t       token
);
    import msgtok_pkg::*;

    logic                     ext_tag;
    logic [63:0]              acc_new;
    logic [7:0]               ext_new;
    logic [3:0]               left_new;
    logic [7:0]               t;
    logic                     do_count;
    logic [CHILD_WIDTH-1:0]   children;
    logic [PENDING_WIDTH-1:0] base_m1;
    logic [PENDING_WIDTH:0]   sum;
    logic [PENDING_WIDTH-1:0] pend_new;

    // header length table, listed per tag
    function automatic logic [3:0] tag_len(input logic [7:0] tg);
        logic [3:0] len;
        case (tg) inside
            MP_BIN8, MP_UINT8, MP_INT8, MP_STR8, MP_FIXEXT1, MP_FIXEXT2,
            MP_FIXEXT4, MP_FIXEXT8, MP_FIXEXT16:                    len = 4'd1;
            MP_BIN16, MP_EXT8, MP_UINT16, MP_INT16, MP_STR16,
            MP_ARRAY16, MP_MAP16:                                   len = 4'd2;
            MP_EXT16:                                               len = 4'd3;
            MP_BIN32, MP_FLOAT32, MP_UINT32, MP_INT32, MP_STR32,
            MP_ARRAY32, MP_MAP32:                                   len = 4'd4;
            MP_EXT32:                                               len = 4'd5;
            MP_FLOAT64, MP_UINT64, MP_INT64:                        len = 4'd8;
            default:                                                len = 4'd0;
        endcase
        return len;
    endfunction

    always_comb
    begin
        nxt      = cur;
        token    = '0;
        do_count = 1'b0;
        children = '0;
        t        = cur.tag;
        ext_tag  = (t == MP_EXT8) || (t == MP_EXT16) || (t == MP_EXT32) ||
                   (t == MP_FIXEXT1) || (t == MP_FIXEXT2) || (t == MP_FIXEXT4) ||
                   (t == MP_FIXEXT8) || (t == MP_FIXEXT16);
        acc_new  = cur.accum;
        ext_new  = cur.ext_hold;
        left_new = cur.hdr_left - 4'd1;

        if (cur.hdr_left != 4'd0)
        begin
            // header byte
            if (ext_tag && cur.hdr_left == 4'd1)
                ext_new = stream_byte;
            else
                acc_new = {cur.accum[55:0], stream_byte};
            nxt.accum    = acc_new;
            nxt.ext_hold = ext_new;
            nxt.hdr_left = left_new;
            if (left_new == 4'd0)
            begin
                token.emit = 1'b1;
                do_count   = 1'b1;
                case (t) inside
                    MP_BIN8, MP_BIN16, MP_BIN32:
                    begin
                        nxt.payload_left = acc_new[31:0];
                        token.kind       = KIND_BIN;
                        token.value      = {32'd0, acc_new[31:0]};
                    end
                    MP_STR8, MP_STR16, MP_STR32:
                    begin
                        nxt.payload_left = acc_new[31:0];
                        token.kind       = KIND_STR;
                        token.value      = {32'd0, acc_new[31:0]};
                    end
                    MP_EXT8, MP_EXT16, MP_EXT32:
                    begin
                        nxt.payload_left = acc_new[31:0];
                        token.kind       = KIND_EXT;
                        token.value      = {32'd0, acc_new[31:0]};
                        token.ext_type   = ext_new;
                    end
                    MP_FIXEXT1, MP_FIXEXT2, MP_FIXEXT4, MP_FIXEXT8, MP_FIXEXT16:
                    begin
                        nxt.payload_left = LEN_WIDTH'(32'd1 << (t[2:0] - 3'd4));
                        token.kind       = KIND_EXT;
                        token.value      = 64'(32'd1 << (t[2:0] - 3'd4));
                        token.ext_type   = ext_new;
                    end
                    MP_FLOAT32:
                    begin
                        token.kind  = KIND_F32;
                        token.value = {32'd0, acc_new[31:0]};
                    end
                    MP_FLOAT64:
                    begin
                        token.kind  = KIND_F64;
                        token.value = acc_new;
                    end
                    MP_UINT8, MP_UINT16, MP_UINT32, MP_UINT64:
                    begin
                        token.kind  = KIND_UINT;
                        token.value = acc_new;
                    end
                    MP_INT8:
                    begin
                        token.kind  = KIND_INT;
                        token.value = {{56{acc_new[7]}}, acc_new[7:0]};
                    end
                    MP_INT16:
                    begin
                        token.kind  = KIND_INT;
                        token.value = {{48{acc_new[15]}}, acc_new[15:0]};
                    end
                    MP_INT32:
                    begin
                        token.kind  = KIND_INT;
                        token.value = {{32{acc_new[31]}}, acc_new[31:0]};
                    end
                    MP_INT64:
                    begin
                        token.kind  = KIND_INT;
                        token.value = acc_new;
                    end
                    MP_ARRAY16, MP_ARRAY32:
                    begin
                        token.kind  = KIND_ARRAY;
                        token.value = {32'd0, acc_new[31:0]};
                        children    = {1'b0, acc_new[31:0]};
                    end
                    default:
                    begin
                        // map16 and map32: two children per entry
                        token.kind  = KIND_MAP;
                        token.value = {32'd0, acc_new[31:0]};
                        children    = {acc_new[31:0], 1'b0};
                    end
                endcase
            end
        end
        else if (cur.payload_left != '0)
        begin
            nxt.payload_left = cur.payload_left - LEN_WIDTH'(1);
            token.emit       = payload_pass;
            token.kind       = KIND_BYTE;
            token.value      = {56'd0, stream_byte};
        end
        else if (!stream_byte[7])
        begin
            token.emit  = 1'b1;
            do_count    = 1'b1;
            token.kind  = KIND_INT;
            token.value = {56'd0, stream_byte};
        end
        else if (stream_byte[7:4] == 4'h8)
        begin
            token.emit  = 1'b1;
            do_count    = 1'b1;
            token.kind  = KIND_MAP;
            token.value = {60'd0, stream_byte[3:0]};
            children    = {28'd0, stream_byte[3:0], 1'b0};
        end
        else if (stream_byte[7:4] == 4'h9)
        begin
            token.emit  = 1'b1;
            do_count    = 1'b1;
            token.kind  = KIND_ARRAY;
            token.value = {60'd0, stream_byte[3:0]};
            children    = {29'd0, stream_byte[3:0]};
        end
        else if (stream_byte[7:5] == 3'b101)
        begin
            token.emit       = 1'b1;
            do_count         = 1'b1;
            token.kind       = KIND_STR;
            token.value      = {59'd0, stream_byte[4:0]};
            nxt.payload_left = {27'd0, stream_byte[4:0]};
        end
        else if (stream_byte[7:5] == 3'b111)
        begin
            token.emit  = 1'b1;
            do_count    = 1'b1;
            token.kind  = KIND_INT;
            token.value = {56'hff_ffff_ffff_ffff, stream_byte};
        end
        else if (stream_byte == MP_NIL)
        begin
            token.emit = 1'b1;
            do_count   = 1'b1;
            token.kind = KIND_NIL;
        end
        else if (stream_byte == MP_INVALID)
        begin
            // clear the whole parse
            nxt        = '0;
            token.emit = 1'b1;
            token.kind = KIND_ERROR;
        end
        else if (stream_byte == MP_FALSE || stream_byte == MP_TRUE)
        begin
            token.emit  = 1'b1;
            do_count    = 1'b1;
            token.kind  = KIND_BOOL;
            token.value = {63'd0, stream_byte[0]};
        end
        else
        begin
            nxt.tag      = stream_byte;
            nxt.hdr_left = tag_len(stream_byte);
            nxt.accum    = '0;
            nxt.ext_hold = '0;
        end

        // open-object counter, saturating
        base_m1  = (cur.pending == '0) ? '0 : cur.pending - PENDING_WIDTH'(1);
        sum      = {1'b0, base_m1} + (PENDING_WIDTH + 1)'(children);
        pend_new = sum[PENDING_WIDTH] ? '1 : sum[PENDING_WIDTH-1:0];
        if (do_count)
        begin
            nxt.pending = pend_new;
            token.done  = (pend_new == '0);
        end
    end

endmodule

/* rtl/msgpack_stream_tokenizer.sv */
// channel     | handshake                                 | payload
// ------------+-------------------------------------------+-----------------------------------
// stream in   | stream_valid / stream_stall               | stream_byte
// token out   | token_valid / token_stall                 | token_kind, token_value,
//             |                                           | ext_type, object_done
// config      | payload_pass_valid / payload_pass_ready   | payload_pass
//
// one byte per cycle sustained while the token side does not stall; a byte is captured
// in the input register, decoded from there, and its token is registered in the output register
// rst_n clears the parse state and the counter asynchronously, payload_pass resets to 1
// a stalled token holds the output register; the input register then holds its byte
// and stream_stall rises in the same cycle, so no byte is lost or reordered
// config is always ready and is applied by the next byte that gets decoded
module msgpack_stream_tokenizer (
    input  logic                    clk,
    input  logic                    rst_n,
    // byte stream
    input  logic                    stream_valid,
    output logic                    stream_stall,
    input  logic [7:0]              stream_byte,
    // token stream
    output logic                    token_valid,
    input  logic                    token_stall,
    output msgtok_pkg::token_kind_t token_kind,
    output logic [63:0]             token_value,
    output logic signed [7:0]       ext_type,
    output logic                    object_done,
    // config write
    input  logic                    payload_pass_valid,
    output logic                    payload_pass_ready,
    input  logic                    payload_pass
);
    import msgtok_pkg::*;

    // input register
    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_byte_reg;

    // parse state, updated when the byte in the input register is decoded
    parse_state_t state_reg;
    parse_state_t state_next;
    token_t       dec_token;

    logic         pass_reg;

    // output register
    logic         out_valid_reg;
    logic         out_valid_next;
    token_kind_t  kind_reg;
    logic [63:0]  value_reg;
    logic [7:0]   ext_reg;
    logic         done_reg;

    logic         advance;
    logic         accept;

    // output register is free or drains this cycle
    assign advance      = !out_valid_reg || !token_stall;
    assign stream_stall = in_valid_reg && !advance;
    assign accept       = stream_valid && !stream_stall;

    assign payload_pass_ready = 1'b1;

    msgtok_decode u_decode (
        .cur          (state_reg),
        .stream_byte  (in_byte_reg),
        .payload_pass (pass_reg),
        .nxt          (state_next),
        .token        (dec_token)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = in_valid_reg && dec_token.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            pass_reg      <= 1'b1;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_valid_reg && advance)
                state_reg <= state_next;
            if (payload_pass_valid && payload_pass_ready)
                pass_reg <= payload_pass;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= stream_byte;
        if (advance && in_valid_reg && dec_token.emit)
        begin
            kind_reg  <= dec_token.kind;
            value_reg <= dec_token.value;
            ext_reg   <= dec_token.ext_type;
            done_reg  <= dec_token.done;
        end
    end

    assign token_valid = out_valid_reg;
    assign token_kind  = kind_reg;
    assign token_value = value_reg;
    assign ext_type    = ext_reg;
    assign object_done = done_reg;

endmodule

/* rtl/msgtok_checker.sv */
module msgtok_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    stream_valid,
    input logic                    stream_stall,
    input logic [7:0]              stream_byte,
    input logic                    token_valid,
    input logic                    token_stall,
    input msgtok_pkg::token_kind_t token_kind,
    input logic [63:0]             token_value,
    input logic signed [7:0]       ext_type,
    input logic                    object_done,
    input logic                    payload_pass_valid,
    input logic                    payload_pass_ready,
    input logic                    payload_pass
);
    import msgtok_pkg::*;

    // a stalled token stays put
    a_token_hold: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=> token_valid && $stable(token_kind) &&
        $stable(token_value) && $stable(ext_type) && $stable(object_done))
        else $error("token changed under stall");

    // error token carries nothing
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind == KIND_ERROR |->
        token_value == 64'd0 && ext_type == 8'sd0 && !object_done)
        else $error("error token not clean");

    // ext type only rides on ext tokens
    a_ext_only: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind != KIND_EXT |-> ext_type == 8'sd0)
        else $error("ext type on non-ext token");

    // payload bytes never close an object
    a_byte_token: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind == KIND_BYTE |->
        token_value[63:8] == 56'd0 && !object_done)
        else $error("bad payload byte token");

endmodule

bind msgpack_stream_tokenizer msgtok_checker u_msgtok_checker (.*);

/* bench/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msgtok_pkg::*;

    // first bytes of the fix forms that carry their count or value in the tag
    localparam logic [7:0] FIXMAP_BASE     = 8'h80;
    localparam logic [7:0] FIXARRAY_BASE   = 8'h90;
    localparam logic [7:0] FIXSTR_BASE     = 8'ha0;
    localparam logic [7:0] NEG_FIXINT_BASE = 8'he0;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 96;
    localparam int NOISE_PCT    = 15;

    // fix forms at their extremes, nil, both bools, int8 min, uint8 max, an empty map,
    // an open array cut short by the invalid tag, 0xc1 as payload and as header data,
    // and a fixext with the most negative type
    localparam logic [7:0] DIRECTED [21] = '{
        8'h00, 8'h7f, NEG_FIXINT_BASE, 8'hff, MP_NIL, MP_FALSE, MP_TRUE,
        MP_INT8, 8'h80, MP_UINT8, 8'hff, FIXMAP_BASE,
        FIXARRAY_BASE + 8'd1, MP_INVALID, FIXSTR_BASE + 8'd1, MP_INVALID,
        MP_INT8, MP_INVALID, MP_FIXEXT1, 8'h80, 8'haa
    };

    typedef struct {
        token_kind_t kind;
        logic [63:0] value;
        logic [7:0]  ext;
        logic        done;
    } token_rec_t;

    // byte-level decoder model plus the queue of tokens it still owes
    class token_scoreboard;
        bit                       pass_en;
        logic [7:0]               tag;
        logic [3:0]               hdr_left;
        logic [63:0]              accum;
        logic [7:0]               ext_hold;
        logic [32:0]              payload_left;
        logic [PENDING_WIDTH-1:0] open_objects;
        token_rec_t               expected_tokens[$];
        int                       errors;

        function new();
            pass_en = 1'b1;
            errors  = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            tag          = '0;
            hdr_left     = '0;
            accum        = '0;
            ext_hold     = '0;
            payload_left = '0;
            open_objects = '0;
        endfunction

        function logic [3:0] header_len(input logic [7:0] t);
            case (t)
                MP_BIN8, MP_UINT8, MP_INT8, MP_STR8, MP_FIXEXT1, MP_FIXEXT2,
                MP_FIXEXT4, MP_FIXEXT8, MP_FIXEXT16:                 return 4'd1;
                MP_BIN16, MP_EXT8, MP_UINT16, MP_INT16, MP_STR16,
                MP_ARRAY16, MP_MAP16:                                return 4'd2;
                MP_EXT16:                                            return 4'd3;
                MP_BIN32, MP_FLOAT32, MP_UINT32, MP_INT32, MP_STR32,
                MP_ARRAY32, MP_MAP32:                                return 4'd4;
                MP_EXT32:                                            return 4'd5;
                MP_FLOAT64, MP_UINT64, MP_INT64:                     return 4'd8;
                default:                                             return 4'd0;
            endcase
        endfunction

        function logic [63:0] sign_extend(input logic [63:0] v, input int bits);
            case (bits)
                8:       return {{56{v[7]}}, v[7:0]};
                16:      return {{48{v[15]}}, v[15:0]};
                32:      return {{32{v[31]}}, v[31:0]};
                default: return v;
            endcase
        endfunction

        // retire one open object (opening one if idle), add children, saturate
        function token_rec_t close_item(input token_kind_t kind, input logic [63:0] value,
                                        input logic [7:0] ext, input logic [63:0] children);
            token_rec_t  tok;
            logic [63:0] cur;
            logic [63:0] rest;
            logic [63:0] top;
            cur  = 64'(open_objects);
            rest = (cur == 64'd0) ? 64'd0 : cur - 64'd1;
            top  = {64{1'b1}} >> (64 - PENDING_WIDTH);
            if (children > top - rest)
                open_objects = top[PENDING_WIDTH-1:0];
            else
                open_objects = PENDING_WIDTH'(rest + children);
            tok.kind  = kind;
            tok.value = value;
            tok.ext   = ext;
            tok.done  = (open_objects == '0);
            return tok;
        endfunction

        function token_rec_t finish_header();
            logic [63:0] len;
            len = {32'd0, accum[31:0]};
            case (tag)
                MP_BIN8, MP_BIN16, MP_BIN32:
                begin
                    payload_left = len[32:0];
                    return close_item(KIND_BIN, len, 8'd0, 64'd0);
                end
                MP_STR8, MP_STR16, MP_STR32:
                begin
                    payload_left = len[32:0];
                    return close_item(KIND_STR, len, 8'd0, 64'd0);
                end
                MP_EXT8, MP_EXT16, MP_EXT32:
                begin
                    payload_left = len[32:0];
                    return close_item(KIND_EXT, len, ext_hold, 64'd0);
                end
                MP_FIXEXT1, MP_FIXEXT2, MP_FIXEXT4, MP_FIXEXT8, MP_FIXEXT16:
                begin
                    payload_left = 33'd1 << (tag - MP_FIXEXT1);
                    return close_item(KIND_EXT, 64'(payload_left), ext_hold, 64'd0);
                end
                MP_FLOAT32:
                    return close_item(KIND_F32, len, 8'd0, 64'd0);
                MP_FLOAT64:
                    return close_item(KIND_F64, accum, 8'd0, 64'd0);
                MP_UINT8, MP_UINT16, MP_UINT32, MP_UINT64:
                    return close_item(KIND_UINT, accum, 8'd0, 64'd0);
                MP_INT8, MP_INT16, MP_INT32, MP_INT64:
                    return close_item(KIND_INT, sign_extend(accum, 8 << (tag - MP_INT8)),
                                      8'd0, 64'd0);
                MP_ARRAY16, MP_ARRAY32:
                    return close_item(KIND_ARRAY, len, 8'd0, len);
                default:
                    return close_item(KIND_MAP, len, 8'd0, len << 1);
            endcase
        endfunction

        // one stream byte in, at most one token out
        function bit decode_byte(input logic [7:0] b, output token_rec_t tok);
            bit is_ext;
            if (hdr_left != 4'd0)
            begin
                is_ext = (tag >= MP_EXT8 && tag <= MP_EXT32) ||
                         (tag >= MP_FIXEXT1 && tag <= MP_FIXEXT16);
                if (is_ext && hdr_left == 4'd1)
                    ext_hold = b;
                else
                    accum = {accum[55:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left != 4'd0)
                    return 1'b0;
                tok = finish_header();
                return 1'b1;
            end
            if (payload_left != '0)
            begin
                payload_left = payload_left - 33'd1;
                if (!pass_en)
                    return 1'b0;
                tok = '{KIND_BYTE, {56'd0, b}, 8'd0, 1'b0};
                return 1'b1;
            end
            if (b < FIXMAP_BASE)
                tok = close_item(KIND_INT, {56'd0, b}, 8'd0, 64'd0);
            else if (b < FIXARRAY_BASE)
                tok = close_item(KIND_MAP, {60'd0, b[3:0]}, 8'd0, {59'd0, b[3:0], 1'b0});
            else if (b < FIXSTR_BASE)
                tok = close_item(KIND_ARRAY, {60'd0, b[3:0]}, 8'd0, {60'd0, b[3:0]});
            else if (b < MP_NIL)
            begin
                payload_left = {28'd0, b[4:0]};
                tok = close_item(KIND_STR, {59'd0, b[4:0]}, 8'd0, 64'd0);
            end
            else if (b >= NEG_FIXINT_BASE)
                tok = close_item(KIND_INT, sign_extend({56'd0, b}, 8), 8'd0, 64'd0);
            else if (b == MP_NIL)
                tok = close_item(KIND_NIL, 64'd0, 8'd0, 64'd0);
            else if (b == MP_INVALID)
            begin
                clear_parse();
                tok = '{KIND_ERROR, 64'd0, 8'd0, 1'b0};
            end
            else if (b == MP_FALSE || b == MP_TRUE)
                tok = close_item(KIND_BOOL, {63'd0, b[0]}, 8'd0, 64'd0);
            else
            begin
                tag      = b;
                hdr_left = header_len(b);
                accum    = '0;
                ext_hold = '0;
                return 1'b0;
            end
            return 1'b1;
        endfunction

        // keep str/bin/ext lengths below 256 so every payload can be walked out
        function logic [7:0] guard_length(input logic [7:0] b);
            if (hdr_left == 4'd0)
                return b;
            case (tag)
                MP_BIN16, MP_BIN32, MP_STR16, MP_STR32:
                    if (hdr_left > 4'd1)
                        return 8'd0;
                MP_EXT16, MP_EXT32:
                    if (hdr_left > 4'd2)
                        return 8'd0;
                default: ;
            endcase
            return b;
        endfunction

        function void note_byte(input logic [7:0] b);
            token_rec_t tok;
            if (decode_byte(b, tok))
                expected_tokens.push_back(tok);
        endfunction

        function void check_token(input token_kind_t kind, input logic [63:0] value,
                                  input logic [7:0] ext, input logic done);
            token_rec_t exp_tok;
            if (expected_tokens.size() == 0)
            begin
                $error("token with none pending: kind %0d value %h", kind, value);
                errors++;
                return;
            end
            exp_tok = expected_tokens.pop_front();
            if (kind !== exp_tok.kind)
            begin
                $error("token_kind: expected %0d, got %0d", exp_tok.kind, kind);
                errors++;
            end
            if (value !== exp_tok.value)
            begin
                $error("token_value: expected %h, got %h", exp_tok.value, value);
                errors++;
            end
            if (ext !== exp_tok.ext)
            begin
                $error("ext_type: expected %h, got %h", exp_tok.ext, ext);
                errors++;
            end
            if (done !== exp_tok.done)
            begin
                $error("object_done: expected %b, got %b", exp_tok.done, done);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              stream_valid;
    logic              stream_stall;
    logic [7:0]        stream_byte;
    logic              token_valid;
    logic              token_stall;
    token_kind_t       token_kind;
    logic [63:0]       token_value;
    logic signed [7:0] ext_type;
    logic              object_done;
    logic              payload_pass_valid;
    logic              payload_pass_ready;
    logic              payload_pass;

    // checker follows accepted bytes; tracker follows the planned stream ahead of it
    token_scoreboard sb             = new();
    token_scoreboard stream_tracker = new();
    logic [7:0]      byte_plan[$];
    int              send_gap_pct;
    int              stall_pct;
    int              cycle_count;

    msgpack_stream_tokenizer i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .stream_valid       (stream_valid),
        .stream_stall       (stream_stall),
        .stream_byte        (stream_byte),
        .token_valid        (token_valid),
        .token_stall        (token_stall),
        .token_kind         (token_kind),
        .token_value        (token_value),
        .ext_type           (ext_type),
        .object_done        (object_done),
        .payload_pass_valid (payload_pass_valid),
        .payload_pass_ready (payload_pass_ready),
        .payload_pass       (payload_pass)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // token side: random stall drawn at each falling edge
    initial
    begin
        token_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            token_stall = ($urandom_range(0, 99) < stall_pct);
        end
    end

    // a token moves when valid is high and stall low at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && token_valid && !token_stall)
            sb.check_token(token_kind, token_value, ext_type, object_done);
    end

    // hard stop in case the block hangs
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[msgpack_stream_tokenizer] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- stream planning

    // append one byte to the plan; length fields are clamped unless raw
    function automatic void plan_byte(input logic [7:0] b, input bit raw = 1'b0);
        token_rec_t scratch;
        logic [7:0] v;
        v = raw ? b : stream_tracker.guard_length(b);
        void'(stream_tracker.decode_byte(v, scratch));
        byte_plan.push_back(v);
    endfunction

    // big-endian field of n bytes
    function automatic void plan_field(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            plan_byte(v[i*8 +: 8]);
    endfunction

    function automatic void plan_payload(input int n);
        repeat (n) plan_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 99) < 5)
            return $urandom_range(0, 255);
        return $urandom_range(0, 6);
    endfunction

    function automatic logic [63:0] pick_wide();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one well-formed object with random content; containers nest up to depth 3
    function automatic void plan_object(input int depth);
        int sel;
        int n;
        int k;
        sel = $urandom_range(0, depth >= 3 ? 10 : 12);
        k   = $urandom_range(0, 2);
        case (sel)
            0:  plan_byte(8'($urandom_range(0, 127)));
            1:  plan_byte(NEG_FIXINT_BASE + 8'($urandom_range(0, 31)));
            2:  plan_byte(k == 0 ? MP_NIL : (k == 1 ? MP_FALSE : MP_TRUE));
            3:
            begin
                k = $urandom_range(0, 3);
                plan_byte(MP_UINT8 + 8'(k));
                plan_field(pick_wide(), 1 << k);
            end
            4:
            begin
                k = $urandom_range(0, 3);
                plan_byte(MP_INT8 + 8'(k));
                plan_field(pick_wide(), 1 << k);
            end
            5:
            begin
                k = $urandom_range(0, 1);
                plan_byte(k == 1 ? MP_FLOAT64 : MP_FLOAT32);
                plan_field(pick_wide(), k == 1 ? 8 : 4);
            end
            6:
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 4);
                plan_byte(FIXSTR_BASE + 8'(n));
                plan_payload(n);
            end
            7, 8:
            begin
                n = pick_len();
                plan_byte((sel == 7 ? MP_STR8 : MP_BIN8) + 8'(k));
                plan_field(64'(n), 1 << k);
                plan_payload(n);
            end
            9:
            begin
                n = pick_len();
                plan_byte(MP_EXT8 + 8'(k));
                plan_field(64'(n), 1 << k);
                plan_byte(8'($urandom_range(0, 255)));
                plan_payload(n);
            end
            10:
            begin
                k = $urandom_range(0, 4);
                plan_byte(MP_FIXEXT1 + 8'(k));
                plan_byte(8'($urandom_range(0, 255)));
                plan_payload(1 << k);
            end
            default:
            begin
                // array (11) or map (12), fix form or 16/32-bit count
                n = $urandom_range(0, 3);
                if (k == 0)
                    plan_byte((sel == 11 ? FIXARRAY_BASE : FIXMAP_BASE) + 8'(n));
                else if (sel == 11)
                begin
                    plan_byte(k == 1 ? MP_ARRAY16 : MP_ARRAY32);
                    plan_field(64'(n), k == 1 ? 2 : 4);
                end
                else
                begin
                    plan_byte(k == 1 ? MP_MAP16 : MP_MAP32);
                    plan_field(64'(n), k == 1 ? 2 : 4);
                end
                repeat (sel == 11 ? n : 2 * n) plan_object(depth + 1);
            end
        endcase
    endfunction

    // random bytes: stray tags, cut headers, invalid tags, misaligned objects after
    function automatic void plan_noise();
        repeat ($urandom_range(1, 4)) plan_byte(8'($urandom_range(0, 255)));
    endfunction

    // pad until the tracker expects a tag again
    function automatic void plan_align();
        while (stream_tracker.hdr_left != 4'd0 || stream_tracker.payload_left != '0)
            plan_byte(8'h00);
    endfunction

    function automatic void plan_random(input int n);
        while (byte_plan.size() < n)
        begin
            if ($urandom_range(0, 99) < NOISE_PCT)
                plan_noise();
            else
                plan_object(0);
        end
    endfunction

    // ---------------------------------------------------------------- driving

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            stream_valid = 1'b0;
            @(negedge clk);
        end
        stream_valid = 1'b1;
        stream_byte  = b;
        @(posedge clk);
        while (stream_stall)
            @(posedge clk);
        sb.note_byte(b);
    endtask

    task automatic send_plan();
        while (byte_plan.size() != 0)
            send_byte(byte_plan.pop_front());
        @(negedge clk);
        stream_valid = 1'b0;
    endtask

    // every owed token out, then a drain wait for bytes that produce none
    task automatic wait_drained();
        while (sb.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_payload_pass(input bit v);
        @(negedge clk);
        payload_pass_valid = 1'b1;
        payload_pass       = v;
        @(posedge clk);
        while (!payload_pass_ready)
            @(posedge clk);
        sb.pass_en             = v;
        stream_tracker.pass_en = v;
        @(negedge clk);
        payload_pass_valid = 1'b0;
    endtask

    // one random phase; halfway the sender holds off until all tokens are out
    task automatic run_phase(input bit pass, input int gap, input int stall);
        write_payload_pass(pass);
        send_gap_pct = gap;
        stall_pct    = stall;
        plan_random(PHASE_BYTES / 2);
        send_plan();
        wait_drained();
        plan_random(PHASE_BYTES - PHASE_BYTES / 2);
        send_plan();
        wait_drained();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        stream_valid       = 1'b0;
        stream_byte        = 8'd0;
        payload_pass_valid = 1'b0;
        payload_pass       = 1'b1;
        send_gap_pct       = 0;
        stall_pct          = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed bytes with payload_pass at its reset value, no idling
        foreach (DIRECTED[i])
            plan_byte(DIRECTED[i]);
        send_plan();
        wait_drained();

        run_phase(1'b0, 51, 0);
        run_phase(1'b1, 0, 51);
        run_phase(1'b0, 7, 7);
        run_phase(1'b1, 0, 0);

        // large open-object counts: two nested map32 headers with the largest count,
        // a few scalars against them, then the invalid tag clears the counter
        plan_align();
        repeat (2)
        begin
            plan_byte(MP_MAP32);
            plan_field(64'hffff_ffff, 4);
        end
        repeat (3) plan_byte(MP_NIL);
        plan_byte(MP_INVALID);
        send_plan();
        wait_drained();

        run_phase(1'b1, 7, 7);

        // last: a str32 with the largest length, a few of its payload bytes
        plan_align();
        plan_byte(MP_STR32);
        repeat (4) plan_byte(8'hff, 1'b1);
        plan_payload(20);
        send_plan();
        wait_drained();

        if (sb.errors == 0 && sb.expected_tokens.size() == 0)
            $display("[msgpack_stream_tokenizer] OK");
        else
            $display("[msgpack_stream_tokenizer] ERROR");
        $finish;
    end

endmodule
